FILE: hw/rtl/skmd_pkg.sv
// Shared types and constants for the single-key Morse decoder.
// Holds the configuration register layout, the letter code table and the
// result word type. No dependencies.
package skmd_pkg;

  // Configuration port layout
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LONG_PRESS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_END_GAP    = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'h2000;
  localparam logic [CFG_W-1:0] END_GAP_RESET    = 16'h6000;

  // Letter output
  localparam int unsigned LETTER_W     = 7;
  localparam int unsigned LETTER_COUNT = 26;
  localparam logic [LETTER_W-1:0] ASCII_A = 7'd65;

  // Morse codes of A..Z: symbol count, and pattern with bit i = symbol i (1 = dash)
  localparam logic [3:0] CODE_LEN [LETTER_COUNT] = '{
    4'd2, 4'd4, 4'd4, 4'd3, 4'd1, 4'd4, 4'd3, 4'd4, 4'd2, 4'd4, 4'd3, 4'd4, 4'd2,
    4'd2, 4'd3, 4'd4, 4'd4, 4'd3, 4'd3, 4'd1, 4'd3, 4'd4, 4'd3, 4'd4, 4'd4, 4'd4
  };
  localparam logic [7:0] CODE_PAT [LETTER_COUNT] = '{
    8'd2, 8'd1, 8'd5,  8'd1, 8'd0, 8'd4, 8'd3, 8'd0, 8'd0, 8'd14, 8'd5, 8'd2, 8'd3,
    8'd1, 8'd7, 8'd6, 8'd11, 8'd2, 8'd0, 8'd1, 8'd4, 8'd8, 8'd6, 8'd9, 8'd13, 8'd3
  };

  typedef struct packed {
    logic [CFG_W-1:0] long_press_ticks;
    logic [CFG_W-1:0] end_gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic                valid;
    logic [LETTER_W-1:0] letter;
  } letter_t;

endpackage

FILE: hw/rtl/single_key_morse_decoder.sv
// Single-key Morse decoder top level: input register, keying core, result
// register and configuration registers. Depends on skmd_pkg, skmd_cfg_regs
// and skmd_core.
//
// The block takes one sampled key level per word on the slave stream and
// turns presses and releases into dots and dashes. A press held for
// long_press_ticks samples is a dash, a shorter press is a dot; a silence of
// end_gap_ticks samples after a release ends the character, and if it
// matches one of the letters A to Z its ASCII code leaves on the master
// stream. Characters with more than MAX_SYMBOLS symbols, or with a sequence
// that is no letter, produce no output word. The tick counter is
// COUNT_WIDTH bits wide and saturates, so a threshold above its range never
// fires. The block accepts one word per clock cycle unless the slave side
// stalls; the sample that ends a character is held in the input register,
// and its letter is valid on the master side once the core processes it,
// held in the result register until taken. A stalled master side holds the
// result register and, once the input register is also full, the slave
// side. Registers are written through the cfg port (index 0: long press,
// index 1: end gap, other indexes ignored) by the user only while the
// stream is idle, which the block does not enforce; the port never stalls.
module single_key_morse_decoder
  import skmd_pkg::*;
#(
  parameter int unsigned MAX_SYMBOLS = 6,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Slave stream: key samples
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [0] key_down, [7:1] zero
  // Master stream: decoded letters
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // [6:0] letter, [7] zero
  // Configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic                in_valid_q, in_valid_d;
  logic                in_key_q;
  logic                out_valid_q, out_valid_d;
  logic [LETTER_W-1:0] out_letter_q;
  logic                advance, step;
  cfg_t                cfg;
  letter_t             result;

  // Move the pipeline whenever the result register is free or being taken
  assign advance = !out_valid_q || m_axis_tready;
  assign step    = in_valid_q && advance;

  assign s_axis_tready = !in_valid_q || advance;
  assign in_valid_d    = s_axis_tready ? s_axis_tvalid : in_valid_q;
  assign out_valid_d   = advance ? (step && result.valid) : out_valid_q;

  assign cfg_ready_o = 1'b1;

  skmd_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  skmd_core #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .key_i    (in_key_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: capture the sample on accept, the letter when one is decoded
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_key_q <= s_axis_tdata[0];
    end
    if (step && result.valid) begin
      out_letter_q <= result.letter;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_letter_q};

endmodule

FILE: hw/rtl/skmd_cfg_regs.sv
// Configuration registers of the single-key Morse decoder.
// Depends on skmd_pkg.
module skmd_cfg_regs
  import skmd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [CFG_IDX_W-1:0] wr_index_i,
  input  logic [CFG_W-1:0]     wr_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      // Drop writes to indexes outside the register list
      if (wr_index_i == CFG_IDX_LONG_PRESS) begin
        cfg_d.long_press_ticks = wr_data_i;
      end else if (wr_index_i == CFG_IDX_END_GAP) begin
        cfg_d.end_gap_ticks = wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ticks <= LONG_PRESS_RESET;
      cfg_q.end_gap_ticks    <= END_GAP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/skmd_core.sv
// Keying state machine, symbol collector and letter decoder.
// Processes one key sample per enabled cycle. Depends on skmd_pkg.
module skmd_core
  import skmd_pkg::*;
#(
  parameter int unsigned MAX_SYMBOLS = 6,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  logic    key_i,
  input  cfg_t    cfg_i,
  output letter_t result_o
);

  localparam int unsigned SYM_CNT_W = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned SYM_IDX_W = $clog2(MAX_SYMBOLS);
  localparam int unsigned CMP_W     = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PRESSED,
    PH_RELEASED
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic                   key_level_q, key_level_d;
  logic [COUNT_WIDTH-1:0] tick_q, tick_d;
  logic [MAX_SYMBOLS-1:0] sym_bits_q, sym_bits_d;
  logic [SYM_CNT_W-1:0]   sym_count_q, sym_count_d;
  logic                   too_long_q, too_long_d;

  logic                   tick_inc_valid;
  logic [COUNT_WIDTH-1:0] tick_inc;
  logic                   add_req, add_dash, char_end;
  logic                   sym_full;
  letter_t                decoded;

  // Saturating tick count
  assign tick_inc = (tick_q == '1) ? tick_q : tick_q + COUNT_WIDTH'(1);
  assign tick_inc_valid = 1'b1;
  assign sym_full = too_long_q || (sym_count_q >= SYM_CNT_W'(MAX_SYMBOLS));

  // Match the collected symbols against all letter codes
  always_comb begin
    decoded = '0;
    for (int i = 0; i < LETTER_COUNT; i++) begin
      if ((4'(sym_count_q) == CODE_LEN[i]) && (8'(sym_bits_q) == CODE_PAT[i])) begin
        decoded.valid  = 1'b1;
        decoded.letter = ASCII_A + LETTER_W'(i);
      end
    end
  end

  always_comb begin
    phase_d     = phase_q;
    key_level_d = key_level_q;
    tick_d      = tick_q;
    sym_bits_d  = sym_bits_q;
    sym_count_d = sym_count_q;
    too_long_d  = too_long_q;
    add_req     = 1'b0;
    add_dash    = 1'b0;
    char_end    = 1'b0;

    if (key_i != key_level_q) begin
      key_level_d = key_i;
      tick_d      = '0;
      if (!key_i) begin
        add_req = (phase_q == PH_PRESSED);
        phase_d = PH_RELEASED;
      end else begin
        phase_d = PH_PRESSED;
      end
    end else if (tick_inc_valid && (phase_q == PH_PRESSED)) begin
      tick_d = tick_inc;
      if (CMP_W'(tick_inc) >= CMP_W'(cfg_i.long_press_ticks)) begin
        add_req  = 1'b1;
        add_dash = 1'b1;
        phase_d  = PH_IDLE;
      end
    end else if (phase_q == PH_RELEASED) begin
      tick_d = tick_inc;
      if (CMP_W'(tick_inc) >= CMP_W'(cfg_i.end_gap_ticks)) begin
        char_end = 1'b1;
        phase_d  = PH_IDLE;
      end
    end

    if (add_req) begin
      if (sym_full) begin
        too_long_d = 1'b1;
      end else begin
        sym_bits_d[sym_count_q[SYM_IDX_W-1:0]] = add_dash;
        sym_count_d = sym_count_q + SYM_CNT_W'(1);
      end
    end

    if (char_end) begin
      sym_bits_d  = '0;
      sym_count_d = '0;
      too_long_d  = 1'b0;
    end
  end

  always_comb begin
    result_o        = decoded;
    result_o.valid  = step_i && char_end && !too_long_q && decoded.valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      key_level_q <= 1'b0;
      tick_q      <= '0;
      sym_bits_q  <= '0;
      sym_count_q <= '0;
      too_long_q  <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      key_level_q <= key_level_d;
      tick_q      <= tick_d;
      sym_bits_q  <= sym_bits_d;
      sym_count_q <= sym_count_d;
      too_long_q  <= too_long_d;
    end
  end

endmodule
